/* sv/point_in_polygon_crossing_test_macros.svh */
// assertion macros shared by the point-in-polygon rtl
// no dependencies; include with the bare file name
`ifndef POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define PIP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pip assertion failed");
// next-cycle implication, disabled during reset
`define PIP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PIP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/pip_pkg.sv */
// shared constants and types for the point-in-polygon crossing test
// no dependencies
package pip_pkg;

    localparam int COORD_BITS_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    typedef enum logic {
        CFG_QUERY_X = 1'b0,
        CFG_QUERY_Y = 1'b1
    } t_cfg_idx;

    // per-job control bits from front to back
    typedef struct packed {
        logic first;    // vertex opens a polygon, no previous edge
        logic last;     // vertex closes the polygon, closing edge follows
    } t_job_flags;

    localparam int JOB_FLAG_BITS = $bits(t_job_flags);

endpackage

/* sv/pip_front.sv */
// front end: accepts vertices, tracks first and previous vertex, builds edge jobs
// depends on pip_pkg
module pip_front #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_BITS-1:0]       i_vertex_x,
    input  logic [COORD_BITS-1:0]       i_vertex_y,
    input  logic                        i_last_vertex,
    output logic                        o_push,
    input  logic                        i_push_ready,
    output pip_pkg::t_job_flags         o_job_flags,
    output logic [6*COORD_BITS-1:0]     o_job_coords
);

    logic                  r_open;
    logic [COORD_BITS-1:0] r_first_x;
    logic [COORD_BITS-1:0] r_first_y;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic [COORD_BITS-1:0] n_first_x;
    logic [COORD_BITS-1:0] n_first_y;
    logic                  accept;

    assign o_ready = i_push_ready;
    assign o_push  = i_valid;
    assign accept  = i_valid && i_push_ready;

    // a new polygon takes the current vertex as its first one
    assign n_first_x = r_open ? r_first_x : i_vertex_x;
    assign n_first_y = r_open ? r_first_y : i_vertex_y;

    assign o_job_flags.first = !r_open;
    assign o_job_flags.last  = i_last_vertex;
    assign o_job_coords = {i_vertex_x, i_vertex_y, r_prev_x, r_prev_y, n_first_x, n_first_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (accept) begin
            r_open <= !i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x  <= i_vertex_x;
            r_prev_y  <= i_vertex_y;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
        end
    end

endmodule

/* sv/pip_queue.sv */
// small fifo decoupling the front end from the arithmetic back end
// depends on pip_pkg and the assertion macro header
`include "point_in_polygon_crossing_test_macros.svh"
module pip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pip_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_push_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign wr_en        = i_push && o_push_ready;
    assign rd_en        = i_pop && o_valid;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `PIP_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(DEPTH))
    `PIP_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n, rd_en && !wr_en, r_count == $past(r_count) - 1'b1)

endmodule

/* sv/pip_back.sv */
// back end: per-edge straddle test, cross-multiplied crossing compare, parity
// depends on pip_pkg and the assertion macro header
`include "point_in_polygon_crossing_test_macros.svh"
module pip_back #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_pop,
    input  pip_pkg::t_job_flags         i_job_flags,
    input  logic [6*COORD_BITS-1:0]     i_job_coords,
    input  logic [COORD_BITS-1:0]       i_query_x,
    input  logic [COORD_BITS-1:0]       i_query_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_inside_res
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;          // exact difference width
    localparam int PW = 2 * DW;         // exact product width

    // lane 0: previous -> current, lane 1: current -> first (closing edge)
    logic signed [C-1:0]  x1 [2];
    logic signed [C-1:0]  y1 [2];
    logic signed [C-1:0]  x2 [2];
    logic signed [C-1:0]  y2 [2];
    logic signed [C-1:0]  qx;
    logic signed [C-1:0]  qy;
    logic                 lane_en [2];

    logic                 adv;
    logic                 r_s1_v;
    pip_pkg::t_job_flags  r_s1_flags;
    logic signed [DW-1:0] r_s1_ayq [2];
    logic signed [DW-1:0] r_s1_dx  [2];
    logic signed [DW-1:0] r_s1_axq [2];
    logic signed [DW-1:0] r_s1_dy  [2];
    logic                 r_s1_str [2];

    logic                 r_s2_v;
    pip_pkg::t_job_flags  r_s2_flags;
    logic signed [PW-1:0] r_s2_l [2];
    logic signed [PW-1:0] r_s2_r [2];
    logic                 r_s2_str   [2];
    logic                 r_s2_dypos [2];

    logic                 toggle [2];
    logic                 r_parity;
    logic                 n_parity;
    logic                 r_out_valid;
    logic                 r_out;

    assign qx = i_query_x;
    assign qy = i_query_y;
    assign x2[0] = i_job_coords[6*C-1:5*C];
    assign y2[0] = i_job_coords[5*C-1:4*C];
    assign x1[0] = i_job_coords[4*C-1:3*C];
    assign y1[0] = i_job_coords[3*C-1:2*C];
    assign x1[1] = i_job_coords[6*C-1:5*C];
    assign y1[1] = i_job_coords[5*C-1:4*C];
    assign x2[1] = i_job_coords[2*C-1:C];
    assign y2[1] = i_job_coords[C-1:0];
    assign lane_en[0] = !i_job_flags.first;
    assign lane_en[1] = i_job_flags.last;

    // whole pipe moves unless a finished result is waiting
    assign adv       = !r_out_valid || i_ready;
    assign o_job_pop = adv;

    for (genvar g = 0; g < 2; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s1_ayq[g] <= DW'({qy[C-1], qy}) - DW'({y1[g][C-1], y1[g]});
                r_s1_dx[g]  <= DW'({x2[g][C-1], x2[g]}) - DW'({x1[g][C-1], x1[g]});
                r_s1_axq[g] <= DW'({qx[C-1], qx}) - DW'({x1[g][C-1], x1[g]});
                r_s1_dy[g]  <= DW'({y2[g][C-1], y2[g]}) - DW'({y1[g][C-1], y1[g]});
                r_s1_str[g] <= lane_en[g] && ((y1[g] > qy) != (y2[g] > qy));
                r_s2_l[g]     <= r_s1_ayq[g] * r_s1_dx[g];
                r_s2_r[g]     <= r_s1_axq[g] * r_s1_dy[g];
                r_s2_str[g]   <= r_s1_str[g];
                r_s2_dypos[g] <= (r_s1_dy[g] > 0);
            end
        end
        // crossing strictly right of query; compare flips for a falling edge
        assign toggle[g] = r_s2_str[g] &&
                           (r_s2_dypos[g] ? (r_s2_l[g] > r_s2_r[g]) : (r_s2_r[g] > r_s2_l[g]));
    end

    assign n_parity = (r_s2_flags.first ? 1'b0 : r_parity) ^ toggle[0] ^ toggle[1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_flags <= i_job_flags;
            r_s2_flags <= r_s1_flags;
            r_out      <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_v      <= i_job_valid;
            r_s2_v      <= r_s1_v;
            r_out_valid <= r_s2_v && r_s2_flags.last;
            if (r_s2_v) begin
                r_parity <= n_parity;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out;

    `PIP_ASSERT_IMP(a_first_no_open_edge, i_clk, i_rst_n, r_s2_v && r_s2_flags.first, !r_s2_str[0])
    `PIP_ASSERT_NXT(a_result_only_at_last, i_clk, i_rst_n, adv && !(r_s2_v && r_s2_flags.last),
                    !r_out_valid)

endmodule

/* sv/point_in_polygon_crossing_test.sv */
// top level of the ray-casting point-in-polygon crossing test
// depends on pip_pkg, pip_front, pip_queue and pip_back
//
// usage:
//  - write query_x (index 0) and query_y (index 1) through i_cfg_we / i_cfg_idx /
//    i_cfg_data while the block is idle; a write lands at the clock edge
//  - stream polygon vertices on the input channel, one transaction per vertex
//    (i_valid / o_ready); i_last_vertex marks the final vertex and closes the
//    polygon with the edge back to the first vertex
//  - one result transaction per polygon leaves on o_valid / i_ready, carrying
//    o_inside_res, 1 when the query point lies inside
//  - throughput is one vertex per cycle while o_ready is high; every edge is handled
//    by a three-stage back end (difference, two multipliers per edge, compare and parity)
//  - a result shows on o_valid after the job of the last vertex has passed the job queue,
//    the difference, product and result registers; a stalled output side holds it back
//  - a four-entry job queue parts the front end from the back end; while a result waits
//    and the receiver holds i_ready low the back end freezes, the queue fills and then
//    o_ready drops until the waiting result is taken
//  - reset (synchronous, active low) clears the query to zero, drops any open
//    polygon and empties queue and pipeline
//  - a single-vertex polygon reports outside
module point_in_polygon_crossing_test #(
    parameter int COORD_BITS  = pip_pkg::COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    // vertex channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_vertex_x,
    input  logic [COORD_BITS-1:0] i_vertex_y,
    input  logic                  i_last_vertex,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_inside_res
);

    localparam int JOB_BITS = 6 * COORD_BITS + pip_pkg::JOB_FLAG_BITS;

    // query point registers
    logic [COORD_BITS-1:0] r_query_x;
    logic [COORD_BITS-1:0] r_query_y;

    // front end to queue
    logic                  f_push;
    logic                  q_push_ready;
    pip_pkg::t_job_flags   f_flags;
    logic [6*COORD_BITS-1:0] f_coords;

    // queue to back end
    logic                  q_valid;
    logic                  b_pop;
    logic [JOB_BITS-1:0]   q_data;
    pip_pkg::t_job_flags   q_flags;
    logic [6*COORD_BITS-1:0] q_coords;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg_we) begin
            case (pip_pkg::t_cfg_idx'(i_cfg_idx))
                pip_pkg::CFG_QUERY_X: r_query_x <= i_cfg_data;
                pip_pkg::CFG_QUERY_Y: r_query_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front end: vertex bookkeeping, one edge job per accepted vertex
    pip_front #(
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_last_vertex(i_last_vertex),
        .o_push       (f_push),
        .i_push_ready (q_push_ready),
        .o_job_flags  (f_flags),
        .o_job_coords (f_coords)
    );

    // job queue between front and back
    pip_queue #(
        .WIDTH        (JOB_BITS),
        .DEPTH        (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .o_push_ready (q_push_ready),
        .i_data       ({f_flags, f_coords}),
        .o_valid      (q_valid),
        .i_pop        (b_pop),
        .o_data       (q_data)
    );

    assign q_flags  = q_data[JOB_BITS-1:6*COORD_BITS];
    assign q_coords = q_data[6*COORD_BITS-1:0];

    // back end: straddle, cross-multiplied compare, parity and result register
    pip_back #(
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .o_job_pop    (b_pop),
        .i_job_flags  (q_flags),
        .i_job_coords (q_coords),
        .i_query_x    (r_query_x),
        .i_query_y    (r_query_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_inside_res (o_inside_res)
    );

endmodule

/* test/point_in_polygon_crossing_test_test.sv */
// self-checking testbench for the ray-casting point-in-polygon crossing test
// drives vertex transactions, predicts the inside bit per polygon and checks every result
// depends on pip_pkg and point_in_polygon_crossing_test
`timescale 1ns / 1ps

module point_in_polygon_crossing_test_test;

    localparam int COORD_BITS    = pip_pkg::COORD_BITS_DEFAULT;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;     // well past the three-stage back end plus queue
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, fills the job queue
    localparam int STALL_LIMIT   = 4000;   // cycles without any transaction before giving up
    localparam int PHASE_VERTS   = 200;
    localparam int N_DIRECTED    = 26;

    // one line of the directed table: a vertex transaction or a query register write
    typedef enum logic {
        STEP_VERTEX,
        STEP_QUERY
    } t_step_kind;

    typedef struct {
        t_step_kind        kind;
        pip_pkg::t_cfg_idx reg_idx;
        int                x;             // vertex x, or the register value
        int                y;
        bit                last;
        bit                typed;         // expected inside bit is given in the table
        bit                typed_inside;
    } t_directed_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [COORD_BITS-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [COORD_BITS-1:0] i_vertex_x;
    logic [COORD_BITS-1:0] i_vertex_y;
    logic                  i_last_vertex;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_inside_res;

    point_in_polygon_crossing_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_inside_res  (o_inside_res)
    );

    // inside bits still owed by the block, oldest first
    bit inside_expected[$];

    // predictor copy of the query point and of the open polygon
    int q_x;
    int q_y;
    int poly_first_x;
    int poly_first_y;
    int poly_prev_x;
    int poly_prev_y;
    bit poly_parity;
    bit poly_open;

    // idle rates in percent, changed per phase
    int send_idle_pct;
    int rx_idle_pct;
    bit hold_request;

    int n_errors;
    int n_vertices;
    int n_results;
    int n_cfg_writes;
    int stall_cycles;

    t_directed_step directed_steps [N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // keep the low coordinate bits and sign-extend, as the block sees them
    function automatic int to_coord(input int raw);
        logic signed [COORD_BITS-1:0] t;
        t = raw[COORD_BITS-1:0];
        return int'(t);
    endfunction

    // does this edge straddle the query y with its crossing strictly right of the query x
    // crossing is compared by cross-multiplication, flipped when the y span is negative
    function automatic bit edge_toggles_parity(input int x1, input int y1,
                                               input int x2, input int y2);
        longint dy;
        longint lhs;
        longint rhs;
        if ((y1 > q_y) == (y2 > q_y))
            return 1'b0;
        dy  = longint'(y2) - longint'(y1);
        lhs = (longint'(q_y) - longint'(y1)) * (longint'(x2) - longint'(x1));
        rhs = (longint'(q_x) - longint'(x1)) * dy;
        return (dy > 0) ? (lhs > rhs) : (rhs > lhs);
    endfunction

    // advance the polygon state by one accepted vertex
    function automatic void take_vertex(input int raw_x, input int raw_y, input bit last,
                                        output bit has_result, output bit in_poly);
        int x;
        int y;
        x = to_coord(raw_x);
        y = to_coord(raw_y);
        has_result = 1'b0;
        in_poly    = 1'b0;
        if (!poly_open) begin
            // first vertex opens a polygon, no edge yet
            poly_first_x = x;
            poly_first_y = y;
            poly_parity  = 1'b0;
            poly_open    = 1'b1;
        end else if (edge_toggles_parity(poly_prev_x, poly_prev_y, x, y)) begin
            poly_parity = ~poly_parity;
        end
        poly_prev_x = x;
        poly_prev_y = y;
        if (last) begin
            // closing edge back to the first vertex
            if (edge_toggles_parity(x, y, poly_first_x, poly_first_y))
                poly_parity = ~poly_parity;
            has_result = 1'b1;
            in_poly    = poly_parity;
            poly_open  = 1'b0;
        end
    endfunction

    // offer one vertex transaction and hold it until accepted;
    // valid is left high so a back-to-back vertex never toggles it within a step
    task automatic send_vertex(input int x, input int y, input bit last,
                               input bit typed, input bit typed_inside);
        bit has_result;
        bit in_poly;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_vertex_x    <= x[COORD_BITS-1:0];
        i_vertex_y    <= y[COORD_BITS-1:0];
        i_last_vertex <= last;
        do @(posedge i_clk); while (!o_ready);
        take_vertex(x, y, last, has_result, in_poly);
        if (has_result)
            inside_expected.push_back(typed ? typed_inside : in_poly);
        n_vertices++;
    endtask

    // stop offering, wait for every owed result, then let the pipeline settle
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (inside_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // query register write, lands at the next edge; only called while idle
    task automatic write_query(input pip_pkg::t_cfg_idx idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[COORD_BITS-1:0];
        @(posedge i_clk);
        if (idx == pip_pkg::CFG_QUERY_X)
            q_x = to_coord(data);
        else
            q_y = to_coord(data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cfg_writes++;
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // query values: mostly near the origin, some full range, some at the rails
    function automatic int random_query();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(400) - 200;
        else if (r < 85)
            return int'($urandom);
        return extreme_coord();
    endfunction

    task automatic random_query_write();
        drain_and_settle();
        case ($urandom_range(2))
            0: write_query(pip_pkg::CFG_QUERY_X, random_query());
            1: write_query(pip_pkg::CFG_QUERY_Y, random_query());
            default: begin
                write_query(pip_pkg::CFG_QUERY_X, random_query());
                write_query(pip_pkg::CFG_QUERY_Y, random_query());
            end
        endcase
    endtask

    // result side: random ready, a long hold-off on request, and the checker
    initial begin : result_sink
        int hold_left;
        bit want;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                n_results++;
                if (inside_expected.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result transaction, inside_res %0b",
                             $time, o_inside_res);
                end else begin
                    want = inside_expected.pop_front();
                    if (o_inside_res !== want) begin
                        n_errors++;
                        $display("%0t: inside_res mismatch, expected %0b actual %0b",
                                 $time, want, o_inside_res);
                    end
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: any transaction on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results still owed",
                         $time, STALL_LIMIT, inside_expected.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n_verts;
        int style;
        int spread;
        int vx;
        int vy;
        int sent;
        bit hold_issued;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = pip_pkg::CFG_QUERY_X;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_vertex_x    = '0;
        i_vertex_y    = '0;
        i_last_vertex = 1'b0;
        send_idle_pct = 0;
        rx_idle_pct   = 0;
        hold_request  = 1'b0;
        hold_issued   = 1'b0;
        n_errors      = 0;
        n_vertices    = 0;
        n_results     = 0;
        n_cfg_writes  = 0;
        stall_cycles  = 0;
        q_x           = 0;
        q_y           = 0;
        poly_first_x  = 0;
        poly_first_y  = 0;
        poly_prev_x   = 0;
        poly_prev_y   = 0;
        poly_parity   = 1'b0;
        poly_open     = 1'b0;

        directed_steps = '{
            // one-vertex polygon at the reset query: outside
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,      0,      0, 1'b1, 1'b1, 1'b0},
            // small square around the origin: inside
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,    -10,    -10, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     10,    -10, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     10,     10, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,    -10,     10, 1'b1, 1'b1, 1'b1},
            // square on the coordinate rails: inside
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X, -32768, -32768, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,  32767, -32768, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,  32767,  32767, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X, -32768,  32767, 1'b1, 1'b1, 1'b1},
            // query at the opposite rails, widest spans and products
            '{STEP_QUERY,  pip_pkg::CFG_QUERY_X,  32767,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_QUERY,  pip_pkg::CFG_QUERY_Y, -32768,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X, -32768, -32768, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,  32767,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,      0,  32767, 1'b1, 1'b0, 1'b0},
            '{STEP_QUERY,  pip_pkg::CFG_QUERY_X,      0,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_QUERY,  pip_pkg::CFG_QUERY_Y,      0,      0, 1'b0, 1'b0, 1'b0},
            // horizontal edge lying on the query y
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     -5,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,      5,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,      0,      5, 1'b1, 1'b0, 1'b0},
            // two-vertex polygon through the query, edge and its reverse
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     -3,     -3, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,      3,      3, 1'b1, 1'b0, 1'b0},
            // query moved while the polygon is open
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,    -10,    -10, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     10,    -10, 1'b0, 1'b0, 1'b0},
            '{STEP_QUERY,  pip_pkg::CFG_QUERY_X,     20,      0, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,     10,     10, 1'b0, 1'b0, 1'b0},
            '{STEP_VERTEX, pip_pkg::CFG_QUERY_X,    -10,     10, 1'b1, 1'b0, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling on either side
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_QUERY) begin
                drain_and_settle();
                write_query(directed_steps[i].reg_idx, directed_steps[i].x);
            end else begin
                send_vertex(directed_steps[i].x, directed_steps[i].y, directed_steps[i].last,
                            directed_steps[i].typed, directed_steps[i].typed_inside);
            end
        end

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 11;
                    rx_idle_pct   = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    rx_idle_pct   = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    rx_idle_pct   = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_VERTS) begin
                if ($urandom_range(99) < 8)
                    random_query_write();

                // receiver stalls for a long stretch while vertices keep coming
                if (!hold_issued && sent >= 60) begin
                    hold_request = 1'b1;
                    hold_issued  = 1'b1;
                end

                case ($urandom_range(19))
                    0:       n_verts = 1;
                    1, 2:    n_verts = 2;
                    3, 4:    n_verts = $urandom_range(12, 7);
                    default: n_verts = $urandom_range(6, 3);
                endcase
                style = $urandom_range(9);
                case ($urandom_range(3))
                    0:       spread = 2;
                    1:       spread = 16;
                    2:       spread = 300;
                    default: spread = 5000;
                endcase

                for (int v = 0; v < n_verts; v++) begin
                    // clustered around the query most of the time, so edges straddle it
                    if (style < 6) begin
                        vx = q_x + $urandom_range(2 * spread) - spread;
                        vy = q_y + $urandom_range(2 * spread) - spread;
                    end else if (style < 8) begin
                        vx = int'($urandom);
                        vy = int'($urandom);
                    end else if (style == 8) begin
                        vx = extreme_coord();
                        vy = extreme_coord();
                    end else begin
                        vx = ($urandom_range(1)) ? extreme_coord() : int'($urandom);
                        vy = q_y + $urandom_range(2 * spread) - spread;
                    end
                    send_vertex(vx, vy, (v == n_verts - 1), 1'b0, 1'b0);
                    sent++;
                    // occasional query move with the polygon still open
                    if (v < n_verts - 1 && $urandom_range(99) < 2)
                        random_query_write();
                end
            end
            drain_and_settle();
        end

        // closing writes at the rails so both registers end on extremes too
        write_query(pip_pkg::CFG_QUERY_X, -32768);
        write_query(pip_pkg::CFG_QUERY_Y, 32767);
        send_vertex(-32768, 32767, 1'b0, 1'b0, 1'b0);
        send_vertex(32767, -32768, 1'b0, 1'b0, 1'b0);
        send_vertex(32767, 32767, 1'b1, 1'b0, 1'b0);
        drain_and_settle();

        $display("run covered %0d vertex transactions, %0d polygon results, %0d query writes",
                 n_vertices, n_results, n_cfg_writes);
        $display("idling phases: sender-light, receiver-light, none; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
